@@ rtl/assert_macros.svh @@
// assertion macros shared by the box plane side classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define BPSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpsc assertion failed");

// next-cycle implication, held off while reset is asserted
`define BPSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpsc assertion failed");

`endif

@@ rtl/bpsc_pkg.sv @@
// package: shared constants and types of the box plane side classifier
`timescale 1ns / 1ps

package bpsc_pkg;

	localparam int COORD_WIDTH_DEF      = 24;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	// queue between front and back, and result queue
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// classification handed from front to back
	typedef struct packed {
		logic axial;     // normal is exactly +1.0 on some axis
		logic ax_front;  // axial result, front side
		logic ax_back;   // axial result, back side
	} cls_t;

endpackage

@@ rtl/bpsc_fifo.sv @@
// generic register queue with push/full and pop/empty sides
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpsc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic                         empty,
	output logic [WIDTH-1:0]             rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// occupancy follows the accepted pushes and pops
	`BPSC_ASSERT_NXT(a_cnt_up, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + CNT_W'(1))
	`BPSC_ASSERT_NXT(a_cnt_dn, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - CNT_W'(1))

endmodule

@@ rtl/bpsc_front.sv @@
// front part: axial plane detection and near/far corner selection
`timescale 1ns / 1ps

module bpsc_front
	import bpsc_pkg::*;
#(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
	localparam int NW              = NORMAL_FRAC_BITS + 2,
	localparam int DATA_W          = 3*NW + 7*COORD_WIDTH
) (
	input  logic signed [NW-1:0]          normal_x,
	input  logic signed [NW-1:0]          normal_y,
	input  logic signed [NW-1:0]          normal_z,
	input  logic signed [COORD_WIDTH-1:0] plane_distance,
	input  logic signed [COORD_WIDTH-1:0] box_min_x,
	input  logic signed [COORD_WIDTH-1:0] box_min_y,
	input  logic signed [COORD_WIDTH-1:0] box_min_z,
	input  logic signed [COORD_WIDTH-1:0] box_max_x,
	input  logic signed [COORD_WIDTH-1:0] box_max_y,
	input  logic signed [COORD_WIDTH-1:0] box_max_z,
	output cls_t                          cls,
	output logic [DATA_W-1:0]             data
);

	localparam logic [NW-1:0] NORM_ONE = {2'b01, {NORMAL_FRAC_BITS{1'b0}}};

	logic signed [NW-1:0]          n   [3];
	logic signed [COORD_WIDTH-1:0] lo  [3];
	logic signed [COORD_WIDTH-1:0] hi  [3];
	logic signed [COORD_WIDTH-1:0] far_c  [3];
	logic signed [COORD_WIDTH-1:0] near_c [3];
	logic signed [COORD_WIDTH-1:0] lo_sel, hi_sel;

	assign n[0]  = normal_x;
	assign n[1]  = normal_y;
	assign n[2]  = normal_z;
	assign lo[0] = box_min_x;
	assign lo[1] = box_min_y;
	assign lo[2] = box_min_z;
	assign hi[0] = box_max_x;
	assign hi[1] = box_max_y;
	assign hi[2] = box_max_z;

	// first axis with normal exactly +1.0 wins
	always_comb begin
		cls.axial = 1'b1;
		lo_sel    = lo[0];
		hi_sel    = hi[0];
		priority if (n[0] == NORM_ONE) begin
			lo_sel = lo[0];
			hi_sel = hi[0];
		end else if (n[1] == NORM_ONE) begin
			lo_sel = lo[1];
			hi_sel = hi[1];
		end else if (n[2] == NORM_ONE) begin
			lo_sel = lo[2];
			hi_sel = hi[2];
		end else begin
			cls.axial = 1'b0;
		end
		// front only at or below min, back only at or above max, else both
		cls.ax_front = (plane_distance <= lo_sel) || (plane_distance < hi_sel);
		cls.ax_back  = !(plane_distance <= lo_sel);
	end

	// negative normal component swaps min and max
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			far_c[i]  = n[i][NW-1] ? lo[i] : hi[i];
			near_c[i] = n[i][NW-1] ? hi[i] : lo[i];
		end
	end

	assign data = {plane_distance, near_c[2], near_c[1], near_c[0],
		far_c[2], far_c[1], far_c[0], n[2], n[1], n[0]};

endmodule

@@ rtl/bpsc_back.sv @@
// back part: dot products, compare against scaled distance, result queue
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpsc_back
	import bpsc_pkg::*;
#(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
	localparam int NW              = NORMAL_FRAC_BITS + 2,
	localparam int DATA_W          = 3*NW + 7*COORD_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mid_empty,
	output logic              mid_pop,
	input  cls_t              mid_cls,
	input  logic [DATA_W-1:0] mid_data,
	input  logic              pop,
	output logic              empty,
	output logic              in_front,
	output logic              behind
);

	localparam int PW    = NW + COORD_WIDTH;
	localparam int SW    = PW + 2;
	localparam int OCW   = $clog2(OUT_DEPTH+1);
	localparam int CRW   = OCW + 1;
	localparam int FAR_O = 3*NW;
	localparam int NEAR_O = 3*NW + 3*COORD_WIDTH;
	localparam int PD_O  = 3*NW + 6*COORD_WIDTH;

	logic signed [NW-1:0]          n      [3];
	logic signed [COORD_WIDTH-1:0] far_c  [3];
	logic signed [COORD_WIDTH-1:0] near_c [3];
	logic signed [COORD_WIDTH-1:0] pd;

	logic                          v_s1, v_s2;
	cls_t                          cls_s1, cls_s2;
	logic signed [PW-1:0]          pf_s1 [3];
	logic signed [PW-1:0]          pn_s1 [3];
	logic signed [COORD_WIDTH-1:0] pd_s1;
	logic signed [SW-1:0]          sf_s2, sn_s2, pds_s2;

	logic                          out_full;
	logic [OCW-1:0]                out_count;
	logic [CRW-1:0]                in_flight;
	logic                          res_front, res_back;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n[i]      = mid_data[i*NW +: NW];
			far_c[i]  = mid_data[FAR_O + i*COORD_WIDTH +: COORD_WIDTH];
			near_c[i] = mid_data[NEAR_O + i*COORD_WIDTH +: COORD_WIDTH];
		end
	end
	assign pd = mid_data[PD_O +: COORD_WIDTH];

	// result queue space covers everything in the two stages
	assign in_flight = CRW'(out_count) + CRW'(v_s1) + CRW'(v_s2);
	assign mid_pop   = !mid_empty && (in_flight < CRW'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
		end
	end

	// stage 1: six products
	always_ff @(posedge clk) begin
		cls_s1 <= mid_cls;
		pd_s1  <= pd;
		for (int i = 0; i < 3; i++) begin
			pf_s1[i] <= n[i] * far_c[i];
			pn_s1[i] <= n[i] * near_c[i];
		end
	end

	// stage 2: sums and distance at product scale
	always_ff @(posedge clk) begin
		cls_s2 <= cls_s1;
		sf_s2  <= SW'(pf_s1[0]) + SW'(pf_s1[1]) + SW'(pf_s1[2]);
		sn_s2  <= SW'(pn_s1[0]) + SW'(pn_s1[1]) + SW'(pn_s1[2]);
		pds_s2 <= SW'(pd_s1) <<< NORMAL_FRAC_BITS;
	end

	assign res_front = cls_s2.axial ? cls_s2.ax_front : (sf_s2 >= pds_s2);
	assign res_back  = cls_s2.axial ? cls_s2.ax_back  : (sn_s2 < pds_s2);

	bpsc_fifo #(
		.WIDTH(2),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (v_s2),
		.full  (out_full),
		.wdata ({res_front, res_back}),
		.pop   (pop),
		.empty (empty),
		.rdata ({in_front, behind}),
		.count (out_count)
	);

	// an item leaving stage 2 always finds room
	`BPSC_ASSERT_IMP(a_no_drop, clk, arst_n, v_s2, !out_full)

endmodule

@@ rtl/box_plane_side_classifier_top.sv @@
// top level of the box plane side classifier
`timescale 1ns / 1ps

// Box plane side classifier. Each item is a plane (normal in signed Q1.F,
// F = NORMAL_FRAC_BITS, distance in signed Q16.8) and an axis-aligned box
// (min and max corners in signed Q16.8); the result says whether some part
// of the box lies in front of the plane and whether some part lies behind.
// A normal with one component exactly +1.0 (x checked first, then y, then z)
// is handled as an axial plane with plain compares on that axis; any other
// normal uses exact dot products of the near and far corners against the
// distance scaled to product precision, so nothing is rounded.
// Both sides look like queues: push/full for items, empty/pop for results.
// One item is taken every clock cycle, sustained, while pop is kept high;
// the result of an item passes the entry queue, product stage, sum stage
// and result queue before it is shown. The four-entry result queue is sized
// to hold the two arithmetic stages, which is what keeps the rate at one per
// cycle; when results are not popped, up to six items are held inside before
// full rises. There are no configuration registers and nothing to clear.

module box_plane_side_classifier_top
	import bpsc_pkg::*;
#(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item side
	input  logic                                push,
	output logic                                full,
	input  logic signed [NORMAL_FRAC_BITS+1:0]  normal_x,
	input  logic signed [NORMAL_FRAC_BITS+1:0]  normal_y,
	input  logic signed [NORMAL_FRAC_BITS+1:0]  normal_z,
	input  logic signed [COORD_WIDTH-1:0]       plane_distance,
	input  logic signed [COORD_WIDTH-1:0]       box_min_x,
	input  logic signed [COORD_WIDTH-1:0]       box_min_y,
	input  logic signed [COORD_WIDTH-1:0]       box_min_z,
	input  logic signed [COORD_WIDTH-1:0]       box_max_x,
	input  logic signed [COORD_WIDTH-1:0]       box_max_y,
	input  logic signed [COORD_WIDTH-1:0]       box_max_z,
	// result side
	output logic                                empty,
	input  logic                                pop,
	output logic                                in_front,
	output logic                                behind
);

	localparam int NW     = NORMAL_FRAC_BITS + 2;
	localparam int DATA_W = 3*NW + 7*COORD_WIDTH;
	localparam int CLS_W  = $bits(cls_t);
	localparam int MID_W  = CLS_W + DATA_W;

	cls_t              f_cls, m_cls;
	logic [DATA_W-1:0] f_data, m_data;
	logic              m_empty, m_pop;

	// front: classify the item as it is pushed
	bpsc_front #(
		.COORD_WIDTH     (COORD_WIDTH),
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_front (
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.plane_distance(plane_distance),
		.box_min_x     (box_min_x),
		.box_min_y     (box_min_y),
		.box_min_z     (box_min_z),
		.box_max_x     (box_max_x),
		.box_max_y     (box_max_y),
		.box_max_z     (box_max_z),
		.cls           (f_cls),
		.data          (f_data)
	);

	// short queue between front and back; its full is the item side's full
	bpsc_fifo #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata ({f_cls, f_data}),
		.pop   (m_pop),
		.empty (m_empty),
		.rdata ({m_cls, m_data}),
		.count ()
	);

	// back: products, sums, compares and the result queue
	bpsc_back #(
		.COORD_WIDTH     (COORD_WIDTH),
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(m_empty),
		.mid_pop  (m_pop),
		.mid_cls  (m_cls),
		.mid_data (m_data),
		.pop      (pop),
		.empty    (empty),
		.in_front (in_front),
		.behind   (behind)
	);

endmodule
